// ----- hw/rtl/merkle_root_double_sha256_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the Merkle root core
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef MERKLE_ROOT_DOUBLE_SHA256_CORE_MACROS_SVH
`define MERKLE_ROOT_DOUBLE_SHA256_CORE_MACROS_SVH

// Property that must hold at every edge
`define MRDS_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication
`define MRDS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MRDS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mrds_pkg.sv -----
// ---------------------------------------------------------------------------
// mrds_pkg
// Types, constants and helpers shared by the Merkle root core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrds_pkg;

  localparam int unsigned MAX_LEVELS_DEF = 16;
  localparam int unsigned NODE_W         = 256;
  localparam int unsigned BLOCK_W        = 512;

  // request and result payloads
  typedef struct packed {
    logic [63:0] hash_word0;
    logic [63:0] hash_word1;
    logic [63:0] hash_word2;
    logic [63:0] hash_word3;
    logic        last_leaf;
  } in_t;

  typedef struct packed {
    logic [63:0] root_word0;
    logic [63:0] root_word1;
    logic [63:0] root_word2;
    logic [63:0] root_word3;
  } out_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_READ,
    ST_HASH,
    ST_FIND,
    ST_FIND_RD,
    ST_FOLD,
    ST_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_FIRST,
    DS_PAD,
    DS_OUTER
  } dsha_state_e;

  typedef enum logic [1:0] {
    SHA_IDLE,
    SHA_ROUND,
    SHA_FINAL
  } sha_state_e;

  localparam logic [NODE_W-1:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // reverse the byte order of a 256-bit node
  function automatic logic [NODE_W-1:0] byte_rev256(input logic [NODE_W-1:0] x);
    logic [NODE_W-1:0] r;
    r = '0;
    for (int i = 0; i < NODE_W / 8; i++) begin
      r[8*i +: 8] = x[NODE_W-8-8*i +: 8];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/merkle_root_double_sha256_core.sv -----
// ---------------------------------------------------------------------------
// merkle_root_double_sha256_core
// Streaming Merkle root of transaction hashes (double SHA-256).
// ---------------------------------------------------------------------------
// Leaf hashes arrive one request at a time in display byte order; a request
// with last_leaf set closes the block and the root is returned in display
// order. Every parent node is made by one shared double SHA-256 unit built on
// a single compression round core, with three compressions per combine. A leaf
// takes one combine per level it carries into; the closing request adds a scan
// for the lowest pending node and one combine per level from there up to the
// highest pending node. The block takes no new leaf until the current one is
// stored, or until the root has been taken. More than 2^MAX_LEVELS leaves
// saturate at the top level and then give no true root.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "merkle_root_double_sha256_core_macros.svh"

module merkle_root_double_sha256_core #(
  parameter int unsigned MAX_LEVELS = mrds_pkg::MAX_LEVELS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mrds_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mrds_pkg::out_t out_data_o
);

  localparam int unsigned LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(MAX_LEVELS - 1);

  mrds_pkg::top_state_e state_q, state_d;
  logic [LVL_W-1:0]            lvl_q, lvl_d;
  logic [MAX_LEVELS-1:0]       occ_q, occ_d;
  logic [mrds_pkg::NODE_W-1:0] carry_q, carry_d;
  logic                        last_q, last_d;
  logic                        fold_q, fold_d;

  logic                        wr_en, rd_en, ds_start, ds_busy, ds_done;
  logic [mrds_pkg::NODE_W-1:0] rd_data, ds_left, ds_result;

  // sequencer
  always_comb begin
    state_d  = state_q;
    lvl_d    = lvl_q;
    occ_d    = occ_q;
    carry_d  = carry_q;
    last_d   = last_q;
    fold_d   = fold_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    ds_start = 1'b0;
    ds_left  = carry_q;
    unique case (state_q)
      mrds_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          carry_d = {in_data_i.hash_word0, in_data_i.hash_word1,
                     in_data_i.hash_word2, in_data_i.hash_word3};
          last_d  = in_data_i.last_leaf;
          fold_d  = 1'b0;
          lvl_d   = '0;
          state_d = mrds_pkg::ST_PUSH;
        end
      end
      // climb while the level is taken, else park the carry there
      mrds_pkg::ST_PUSH: begin
        if (occ_q[lvl_q]) begin
          rd_en   = 1'b1;
          state_d = mrds_pkg::ST_READ;
        end else begin
          wr_en         = 1'b1;
          occ_d[lvl_q]  = 1'b1;
          if (last_q) begin
            lvl_d   = '0;
            fold_d  = 1'b1;
            state_d = mrds_pkg::ST_FIND;
          end else begin
            state_d = mrds_pkg::ST_IDLE;
          end
        end
      end
      // stored node on the left, carry on the right
      mrds_pkg::ST_READ: begin
        ds_left      = rd_data;
        ds_start     = 1'b1;
        occ_d[lvl_q] = 1'b0;
        state_d      = mrds_pkg::ST_HASH;
      end
      mrds_pkg::ST_HASH: begin
        if (ds_done) begin
          carry_d = ds_result;
          if (fold_q) begin
            lvl_d   = lvl_q + LVL_W'(1);
            state_d = mrds_pkg::ST_FOLD;
          end else begin
            // saturate at the top level
            lvl_d   = (lvl_q == TOP_LVL) ? lvl_q : lvl_q + LVL_W'(1);
            state_d = mrds_pkg::ST_PUSH;
          end
        end
      end
      // lowest pending node starts the fold
      mrds_pkg::ST_FIND: begin
        if (occ_q[lvl_q] || lvl_q == TOP_LVL) begin
          rd_en   = 1'b1;
          state_d = mrds_pkg::ST_FIND_RD;
        end else begin
          lvl_d = lvl_q + LVL_W'(1);
        end
      end
      mrds_pkg::ST_FIND_RD: begin
        carry_d      = rd_data;
        occ_d[lvl_q] = 1'b0;
        state_d      = mrds_pkg::ST_FOLD;
      end
      // pair with the stored node, or with itself on an empty level
      mrds_pkg::ST_FOLD: begin
        if (occ_q == '0) begin
          state_d = mrds_pkg::ST_OUT;
        end else if (occ_q[lvl_q]) begin
          rd_en   = 1'b1;
          state_d = mrds_pkg::ST_READ;
        end else begin
          ds_start = 1'b1;
          state_d  = mrds_pkg::ST_HASH;
        end
      end
      mrds_pkg::ST_OUT: begin
        if (out_ready_i) state_d = mrds_pkg::ST_IDLE;
      end
      default: state_d = mrds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrds_pkg::ST_IDLE;
      occ_q   <= '0;
      lvl_q   <= '0;
      last_q  <= 1'b0;
      fold_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      lvl_q   <= lvl_d;
      last_q  <= last_d;
      fold_q  <= fold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  mrds_node_store #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (lvl_q),
    .wr_data_i (carry_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (lvl_q),
    .rd_data_o (rd_data)
  );

  mrds_dsha u_dsha (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ds_start),
    .left_i   (ds_left),
    .right_i  (carry_q),
    .busy_o   (ds_busy),
    .done_o   (ds_done),
    .result_o (ds_result)
  );

  assign in_ready_o  = (state_q == mrds_pkg::ST_IDLE);
  assign out_valid_o = (state_q == mrds_pkg::ST_OUT);
  assign out_data_o  = mrds_pkg::out_t'(carry_q);

  // checks
  `MRDS_ASSERT_IMPL(a_root_stack_empty, out_valid_o, occ_q == '0, "root shown with nodes pending")
  `MRDS_ASSERT_IMPL(a_start_when_free, ds_start, !ds_busy, "hash unit started while busy")
  `MRDS_ASSERT_IMPL(a_park_free_level, wr_en, !occ_q[lvl_q], "node parked on a taken level")
  `MRDS_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "ready held after request")

endmodule

// ----- hw/rtl/mrds_sha_core.sv -----
// ---------------------------------------------------------------------------
// mrds_sha_core
// One SHA-256 compression, one round per clock, 16-word schedule window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrds_sha_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mrds_pkg::NODE_W-1:0]   state_i,
  input  logic [mrds_pkg::BLOCK_W-1:0]  block_i,
  output logic                          done_o,
  output logic [mrds_pkg::NODE_W-1:0]   digest_o
);

  mrds_pkg::sha_state_e state_q, state_d;
  logic [5:0]  rnd_q;
  logic [31:0] hin_q [8];
  logic [31:0] wv_q  [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  logic [31:0] t1, t2, w_new;
  logic [mrds_pkg::NODE_W-1:0] digest_q;
  logic done_q;

  // round function and schedule extension
  always_comb begin
    t1 = h_q + (mrds_pkg::rotr32(e_q, 6) ^ mrds_pkg::rotr32(e_q, 11) ^
                mrds_pkg::rotr32(e_q, 25)) + ((e_q & f_q) ^ (~e_q & g_q)) +
         mrds_pkg::SHA_K[rnd_q] + wv_q[0];
    t2 = (mrds_pkg::rotr32(a_q, 2) ^ mrds_pkg::rotr32(a_q, 13) ^
          mrds_pkg::rotr32(a_q, 22)) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
    w_new = wv_q[0] + (mrds_pkg::rotr32(wv_q[1], 7) ^ mrds_pkg::rotr32(wv_q[1], 18) ^
                       (wv_q[1] >> 3)) + wv_q[9] +
            (mrds_pkg::rotr32(wv_q[14], 17) ^ mrds_pkg::rotr32(wv_q[14], 19) ^
             (wv_q[14] >> 10));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mrds_pkg::SHA_IDLE:  if (start_i) state_d = mrds_pkg::SHA_ROUND;
      mrds_pkg::SHA_ROUND: if (rnd_q == 6'd63) state_d = mrds_pkg::SHA_FINAL;
      mrds_pkg::SHA_FINAL: state_d = mrds_pkg::SHA_IDLE;
      default:             state_d = mrds_pkg::SHA_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrds_pkg::SHA_IDLE;
      rnd_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == mrds_pkg::SHA_FINAL);
      if (state_q == mrds_pkg::SHA_ROUND) rnd_q <= rnd_q + 6'd1;
      else rnd_q <= '0;
    end
  end

  // working variables and schedule
  always_ff @(posedge clk_i) begin
    if (state_q == mrds_pkg::SHA_IDLE && start_i) begin
      for (int i = 0; i < 8; i++) hin_q[i] <= state_i[mrds_pkg::NODE_W-32-32*i +: 32];
      for (int i = 0; i < 16; i++) wv_q[i] <= block_i[mrds_pkg::BLOCK_W-32-32*i +: 32];
      a_q <= state_i[255:224]; b_q <= state_i[223:192];
      c_q <= state_i[191:160]; d_q <= state_i[159:128];
      e_q <= state_i[127:96];  f_q <= state_i[95:64];
      g_q <= state_i[63:32];   h_q <= state_i[31:0];
    end else if (state_q == mrds_pkg::SHA_ROUND) begin
      for (int i = 0; i < 15; i++) wv_q[i] <= wv_q[i+1];
      wv_q[15] <= w_new;
      h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
      d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
    end
    if (state_q == mrds_pkg::SHA_FINAL) begin
      digest_q <= {hin_q[0] + a_q, hin_q[1] + b_q, hin_q[2] + c_q, hin_q[3] + d_q,
                   hin_q[4] + e_q, hin_q[5] + f_q, hin_q[6] + g_q, hin_q[7] + h_q};
    end
  end

  assign done_o   = done_q;
  assign digest_o = digest_q;

endmodule

// ----- hw/rtl/mrds_dsha.sv -----
// ---------------------------------------------------------------------------
// mrds_dsha
// Parent node of two display-order nodes: three compressions on one core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrds_dsha (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mrds_pkg::NODE_W-1:0]  left_i,
  input  logic [mrds_pkg::NODE_W-1:0]  right_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [mrds_pkg::NODE_W-1:0]  result_o
);

  mrds_pkg::dsha_state_e state_q, state_d;
  logic                          core_start, core_done;
  logic [mrds_pkg::NODE_W-1:0]   core_state, core_digest;
  logic [mrds_pkg::BLOCK_W-1:0]  core_block;
  logic [mrds_pkg::NODE_W-1:0]   result_q;
  logic                          done_q;

  // phase sequencing and core feed
  always_comb begin
    state_d    = state_q;
    core_start = 1'b0;
    core_state = mrds_pkg::SHA_IV;
    core_block = {mrds_pkg::byte_rev256(left_i), mrds_pkg::byte_rev256(right_i)};
    unique case (state_q)
      mrds_pkg::DS_IDLE: begin
        if (start_i) begin
          core_start = 1'b1;
          state_d    = mrds_pkg::DS_FIRST;
        end
      end
      mrds_pkg::DS_FIRST: begin
        // padding block of a 64-byte message
        core_state = core_digest;
        core_block = {8'h80, 488'd0, 16'h0200};
        if (core_done) begin
          core_start = 1'b1;
          state_d    = mrds_pkg::DS_PAD;
        end
      end
      mrds_pkg::DS_PAD: begin
        // outer hash of the 32-byte digest
        core_block = {core_digest, 8'h80, 232'd0, 16'h0100};
        if (core_done) begin
          core_start = 1'b1;
          state_d    = mrds_pkg::DS_OUTER;
        end
      end
      mrds_pkg::DS_OUTER: begin
        if (core_done) state_d = mrds_pkg::DS_IDLE;
      end
      default: state_d = mrds_pkg::DS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrds_pkg::DS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == mrds_pkg::DS_OUTER) && core_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mrds_pkg::DS_OUTER && core_done) begin
      result_q <= mrds_pkg::byte_rev256(core_digest);
    end
  end

  mrds_sha_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (core_start),
    .state_i  (core_state),
    .block_i  (core_block),
    .done_o   (core_done),
    .digest_o (core_digest)
  );

  assign busy_o   = (state_q != mrds_pkg::DS_IDLE) || done_q;
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- hw/rtl/mrds_node_store.sv -----
// ---------------------------------------------------------------------------
// mrds_node_store
// One 256-bit pending node per tree level; registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrds_node_store #(
  parameter int unsigned MAX_LEVELS = mrds_pkg::MAX_LEVELS_DEF,
  localparam int unsigned LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [LVL_W-1:0]             wr_addr_i,
  input  logic [mrds_pkg::NODE_W-1:0]  wr_data_i,
  input  logic                         rd_en_i,
  input  logic [LVL_W-1:0]             rd_addr_i,
  output logic [mrds_pkg::NODE_W-1:0]  rd_data_o
);

  logic [mrds_pkg::NODE_W-1:0] mem_q [MAX_LEVELS];
  logic [mrds_pkg::NODE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
